// ----- rtl/button_press_classifier_macros.svh -----
// Assertion macros used by the checker file of the button press classifier.
// Each macro expects clk_i and rst_ni in scope.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("button_press_classifier: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("button_press_classifier: next-cycle check failed");

`endif

// ----- rtl/bpc_pkg.sv -----
package bpc_pkg;

  // Word field widths
  localparam int unsigned TimeW   = 64;
  localparam int unsigned LimitW  = 32;
  localparam int unsigned EventW  = 3;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_POLARITY      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_HOLD    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_TIME     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_HOLD  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_WINDOW = 3'd4;

  // Configuration reset values
  localparam logic [LimitW-1:0] PRESS_HOLD_RST    = 32'd20000;
  localparam logic [LimitW-1:0] LONG_TIME_RST     = 32'd1000000;
  localparam logic [LimitW-1:0] RELEASE_HOLD_RST  = 32'd20000;
  localparam logic [LimitW-1:0] DOUBLE_WINDOW_RST = 32'd300000;

  // Debounce phases
  localparam logic [PhaseW-1:0] PH_IDLE             = 4'd0;
  localparam logic [PhaseW-1:0] PH_MAYBE_PRESSED    = 4'd1;
  localparam logic [PhaseW-1:0] PH_PRESSED          = 4'd2;
  localparam logic [PhaseW-1:0] PH_LONG_PRESS       = 4'd3;
  localparam logic [PhaseW-1:0] PH_MAYBE_LONG_REL   = 4'd4;
  localparam logic [PhaseW-1:0] PH_MAYBE_RELEASED   = 4'd5;
  localparam logic [PhaseW-1:0] PH_MAYBE_IDLE       = 4'd6;
  localparam logic [PhaseW-1:0] PH_MAYBE_DOUBLE     = 4'd7;
  localparam logic [PhaseW-1:0] PH_DOUBLE_PRESS     = 4'd8;
  localparam logic [PhaseW-1:0] PH_MAYBE_DOUBLE_REL = 4'd9;

  // Event codes
  localparam logic [EventW-1:0] EV_NONE       = 3'd0;
  localparam logic [EventW-1:0] EV_PRESS      = 3'd1;
  localparam logic [EventW-1:0] EV_LONG       = 3'd2;
  localparam logic [EventW-1:0] EV_RELEASE    = 3'd3;
  localparam logic [EventW-1:0] EV_DOUBLE     = 3'd4;
  localparam logic [EventW-1:0] EV_DOUBLE_REL = 3'd5;

  // Configuration register set
  typedef struct packed {
    logic              high_is_down;
    logic [LimitW-1:0] press_hold;
    logic [LimitW-1:0] long_time;
    logic [LimitW-1:0] release_hold;
    logic [LimitW-1:0] double_window;
  } bpc_cfg_t;

  localparam bpc_cfg_t CFG_RST = '{
    high_is_down:  1'b1,
    press_hold:    PRESS_HOLD_RST,
    long_time:     LONG_TIME_RST,
    release_hold:  RELEASE_HOLD_RST,
    double_window: DOUBLE_WINDOW_RST
  };

  // Outcome of one tick through the phase logic
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [EventW-1:0] event_code;
    logic              set_press;
    logic              set_release;
    logic              pressed;
    logic              released;
  } bpc_step_t;

endpackage

// ----- rtl/bpc_step.sv -----
module bpc_step (
  input  bpc_pkg::bpc_cfg_t            cfg_i,
  input  logic [bpc_pkg::PhaseW-1:0]   phase_i,
  input  logic [bpc_pkg::TimeW-1:0]    press_stamp_i,
  input  logic [bpc_pkg::TimeW-1:0]    release_stamp_i,
  input  logic                         level_i,
  input  logic [bpc_pkg::TimeW-1:0]    now_i,
  output bpc_pkg::bpc_step_t           step_o
);
  import bpc_pkg::*;

  logic              down;
  logic [TimeW-1:0]  press_dt;
  logic [TimeW-1:0]  release_dt;
  logic              press_over;
  logic              long_over;
  logic              release_over;
  logic              window_over;

  // Polarity
  assign down = cfg_i.high_is_down ? level_i : ~level_i;

  // Wrapping elapsed times; upper half nonzero means past any 32-bit limit
  assign press_dt   = now_i - press_stamp_i;
  assign release_dt = now_i - release_stamp_i;

  assign press_over   = (|press_dt[TimeW-1:LimitW]) ||
                        (press_dt[LimitW-1:0] > cfg_i.press_hold);
  assign long_over    = (|press_dt[TimeW-1:LimitW]) ||
                        (press_dt[LimitW-1:0] > cfg_i.long_time);
  assign release_over = (|release_dt[TimeW-1:LimitW]) ||
                        (release_dt[LimitW-1:0] > cfg_i.release_hold);
  assign window_over  = (|release_dt[TimeW-1:LimitW]) ||
                        (release_dt[LimitW-1:0] > cfg_i.double_window);

  // Phase transitions
  always_comb begin
    step_o.phase       = phase_i;
    step_o.event_code  = EV_NONE;
    step_o.set_press   = 1'b0;
    step_o.set_release = 1'b0;
    case (phase_i)
      PH_IDLE: begin
        if (down) begin
          step_o.phase     = PH_MAYBE_PRESSED;
          step_o.set_press = 1'b1;
        end
      end
      PH_MAYBE_PRESSED: begin
        if (!down) begin
          step_o.phase = PH_IDLE;
        end else if (press_over) begin
          step_o.phase      = PH_PRESSED;
          step_o.event_code = EV_PRESS;
        end
      end
      PH_PRESSED: begin
        if (!down) begin
          step_o.phase       = PH_MAYBE_RELEASED;
          step_o.set_release = 1'b1;
        end else if (long_over) begin
          step_o.phase      = PH_LONG_PRESS;
          step_o.event_code = EV_LONG;
        end
      end
      PH_LONG_PRESS: begin
        if (!down) begin
          step_o.phase       = PH_MAYBE_LONG_REL;
          step_o.set_release = 1'b1;
        end
      end
      PH_MAYBE_LONG_REL: begin
        if (down) begin
          step_o.phase = PH_LONG_PRESS;
        end else if (release_over) begin
          step_o.phase = PH_IDLE;
        end
      end
      PH_MAYBE_RELEASED: begin
        if (down) begin
          step_o.phase = PH_PRESSED;
        end else if (release_over) begin
          step_o.phase = PH_MAYBE_IDLE;
        end
      end
      PH_MAYBE_IDLE: begin
        if (down) begin
          step_o.phase     = PH_MAYBE_DOUBLE;
          step_o.set_press = 1'b1;
        end else if (window_over) begin
          step_o.phase      = PH_IDLE;
          step_o.event_code = EV_RELEASE;
        end
      end
      PH_MAYBE_DOUBLE: begin
        // a bounce back up is timed from the earlier release
        if (down) begin
          if (press_over) begin
            step_o.phase      = PH_DOUBLE_PRESS;
            step_o.event_code = EV_DOUBLE;
          end
        end else if (release_over) begin
          step_o.phase = PH_IDLE;
        end
      end
      PH_DOUBLE_PRESS: begin
        if (!down) begin
          step_o.phase       = PH_MAYBE_DOUBLE_REL;
          step_o.set_release = 1'b1;
        end
      end
      PH_MAYBE_DOUBLE_REL: begin
        if (down) begin
          step_o.phase = PH_DOUBLE_PRESS;
        end else if (release_over) begin
          step_o.phase      = PH_IDLE;
          step_o.event_code = EV_DOUBLE_REL;
        end
      end
      default: begin
        step_o.phase = PH_IDLE;
      end
    endcase

    // Status flags follow the new phase
    step_o.pressed  = (step_o.phase == PH_PRESSED) || (step_o.phase == PH_LONG_PRESS);
    step_o.released = (step_o.phase == PH_IDLE);
  end

endmodule

// ----- rtl/button_press_classifier.sv -----
// Channel  Handshake                Payload
// cfg      cfg_we_i                 cfg_index_i, cfg_wdata_i
// in       in_valid_i / in_stall_o  button_level_i, time_now_us_i
// out      out_valid_o / out_stall_i event_code_o, pressed_flag_o, released_flag_o
//
// One word per cycle sustained while the output is not stalled; each word
// passes the input register, then phase logic into the result register.
// The phase register and both time stamps update as a word leaves the input
// register, so each word sees the state left by the one before it.
// rst_ni clears the phase, stamps, valid flags and loads register defaults.
// An output stall holds the result register; the input register keeps
// accepting until it too is full.
module button_press_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          button_level_i,
  input  logic [bpc_pkg::TimeW-1:0]     time_now_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpc_pkg::EventW-1:0]    event_code_o,
  output logic                          pressed_flag_o,
  output logic                          released_flag_o
);
  import bpc_pkg::*;

  bpc_cfg_t           cfg_q;
  logic [PhaseW-1:0]  phase_q;
  logic [TimeW-1:0]   press_stamp_q;
  logic [TimeW-1:0]   release_stamp_q;

  logic               in_vld_q;
  logic               level_q;
  logic [TimeW-1:0]   now_q;

  logic               out_vld_q;
  logic [EventW-1:0]  event_q;
  logic               pressed_q;
  logic               released_q;

  logic               adv;
  logic               take_in;
  logic               fire;
  bpc_step_t          step;

  // Pipeline control
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !adv;
  assign take_in    = in_valid_i && !in_stall_o;
  assign fire       = in_vld_q && adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_POLARITY:      cfg_q.high_is_down  <= cfg_wdata_i[0];
        REG_PRESS_HOLD:    cfg_q.press_hold    <= cfg_wdata_i[LimitW-1:0];
        REG_LONG_TIME:     cfg_q.long_time     <= cfg_wdata_i[LimitW-1:0];
        REG_RELEASE_HOLD:  cfg_q.release_hold  <= cfg_wdata_i[LimitW-1:0];
        REG_DOUBLE_WINDOW: cfg_q.double_window <= cfg_wdata_i[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take_in) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      level_q <= button_level_i;
      now_q   <= time_now_us_i;
    end
  end

  // Phase logic
  bpc_step u_step (
    .cfg_i           (cfg_q),
    .phase_i         (phase_q),
    .press_stamp_i   (press_stamp_q),
    .release_stamp_i (release_stamp_q),
    .level_i         (level_q),
    .now_i           (now_q),
    .step_o          (step)
  );

  // Classifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      press_stamp_q   <= '0;
      release_stamp_q <= '0;
    end else if (fire) begin
      phase_q <= step.phase;
      if (step.set_press) begin
        press_stamp_q <= now_q;
      end
      if (step.set_release) begin
        release_stamp_q <= now_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      event_q    <= step.event_code;
      pressed_q  <= step.pressed;
      released_q <= step.released;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign event_code_o    = event_q;
  assign pressed_flag_o  = pressed_q;
  assign released_flag_o = released_q;

endmodule

// ----- rtl/bpc_check.sv -----
`include "button_press_classifier_macros.svh"

module bpc_check (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_i,
  input logic                          out_valid_i,
  input logic                          out_stall_i,
  input logic [bpc_pkg::EventW-1:0]    event_code_i,
  input logic                          pressed_flag_i,
  input logic                          released_flag_i
);
  import bpc_pkg::*;

  // A stalled result word holds
  `BPC_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(event_code_i))

  // The input side only backs up behind an output stall
  `BPC_ASSERT_NOW(a_stall_cause, in_stall_i, out_stall_i)

  // Pressed and idle are never reported together
  `BPC_ASSERT_NOW(a_flags_excl, out_valid_i, !(pressed_flag_i && released_flag_i))

  // Press and long press land in a pressed phase
  `BPC_ASSERT_NOW(a_press_flag, out_valid_i && (event_code_i == EV_PRESS || event_code_i == EV_LONG), pressed_flag_i)

  // Release events return to idle
  `BPC_ASSERT_NOW(a_rel_flag, out_valid_i && (event_code_i == EV_RELEASE || event_code_i == EV_DOUBLE_REL), released_flag_i)

endmodule

bind button_press_classifier bpc_check u_bpc_check (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_i      (in_stall_o),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .event_code_i    (event_code_o),
  .pressed_flag_i  (pressed_flag_o),
  .released_flag_i (released_flag_o)
);
